@@ design/bclp_pkg.sv @@
// Shared types and constants for the button click / long-press detector.
// Used by bclp_core and the top level; depends on nothing else.
package bclp_pkg;

  // Width of the press counter; the counter saturates at all ones.
  localparam int CountWidth = 8;
  localparam int CfgWidth   = 8;
  // Comparisons between the counter and the 8-bit thresholds use this width.
  localparam int CmpWidth   = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;

  localparam int NumRegs    = 4;
  localparam int AddrWidth  = $clog2(NumRegs) + 2;

  localparam logic [CfgWidth-1:0] ClickMinRst   = CfgWidth'(8);
  localparam logic [CfgWidth-1:0] ClickMaxRst   = CfgWidth'(120);
  localparam logic [CfgWidth-1:0] LongThreshRst = CfgWidth'(254);
  localparam logic [CfgWidth-1:0] HoldTicksRst  = CfgWidth'(255);

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_CONSUME = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_CLICK_MIN   = 2'd0,
    REG_CLICK_MAX   = 2'd1,
    REG_LONG_THRESH = 2'd2,
    REG_HOLD_TICKS  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CfgWidth-1:0] click_min;
    logic [CfgWidth-1:0] click_max;
    logic [CfgWidth-1:0] long_threshold;
    logic [CfgWidth-1:0] click_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic clicked;
    logic long_pressed;
    logic busy_res;
  } res_t;

endpackage

@@ design/bclp_core.sv @@
// Event state of the detector: key tracking, press counter and hold countdown.
// Updates once per accepted item and returns the result for the new state.
// Depends on bclp_pkg.
module bclp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_fire,
  input  bclp_pkg::op_t       item_op,
  input  logic                item_key,
  input  bclp_pkg::cfg_t      cfg,
  output bclp_pkg::res_t      res
);

  localparam logic [bclp_pkg::CountWidth-1:0] CountMax = {bclp_pkg::CountWidth{1'b1}};

  logic                              key_down_r, key_down_nxt;
  logic [bclp_pkg::CountWidth-1:0]   press_count_r, press_count_nxt;
  logic                              half_tick_r, half_tick_nxt;
  logic                              event_closed_r, event_closed_nxt;
  logic [bclp_pkg::CfgWidth-1:0]     hold_cnt_r, hold_cnt_nxt;
  logic [bclp_pkg::CfgWidth-1:0]     hold_dec;

  function automatic logic in_window(input logic [bclp_pkg::CountWidth-1:0] cnt,
                                     input bclp_pkg::cfg_t c);
    logic [bclp_pkg::CmpWidth-1:0] cnt_x;
    logic [bclp_pkg::CmpWidth-1:0] lo_x;
    logic [bclp_pkg::CmpWidth-1:0] hi_x;
    cnt_x = bclp_pkg::CmpWidth'(cnt);
    lo_x  = bclp_pkg::CmpWidth'(c.click_min);
    hi_x  = bclp_pkg::CmpWidth'(c.click_max);
    return (cnt_x > lo_x) && (cnt_x < hi_x);
  endfunction

  function automatic logic above_long(input logic [bclp_pkg::CountWidth-1:0] cnt,
                                      input bclp_pkg::cfg_t c);
    return bclp_pkg::CmpWidth'(cnt) > bclp_pkg::CmpWidth'(c.long_threshold);
  endfunction

  always_comb begin
    key_down_nxt     = key_down_r;
    press_count_nxt  = press_count_r;
    half_tick_nxt    = half_tick_r;
    event_closed_nxt = event_closed_r;
    hold_cnt_nxt     = hold_cnt_r;
    hold_dec         = (hold_cnt_r != '0) ? hold_cnt_r - 1'b1 : hold_cnt_r;
    if (item_op == bclp_pkg::OP_CONSUME) begin
      event_closed_nxt = 1'b1;
    end else if (item_key) begin
      if (!key_down_r) begin
        key_down_nxt     = 1'b1;
        press_count_nxt  = '0;
        event_closed_nxt = 1'b0;
        hold_cnt_nxt     = '0;
      end else begin
        // The counter advances when the half-rate flag wraps back to zero.
        half_tick_nxt = ~half_tick_r;
        if (half_tick_r && (press_count_r != CountMax)) begin
          press_count_nxt = press_count_r + 1'b1;
        end
      end
    end else if (key_down_r) begin
      key_down_nxt = 1'b0;
      if (above_long(press_count_r, cfg)) begin
        event_closed_nxt = 1'b1;
        press_count_nxt  = '0;
      end else if (in_window(press_count_r, cfg)) begin
        hold_cnt_nxt = cfg.click_hold_ticks;
      end
    end else if (!event_closed_r) begin
      hold_cnt_nxt = hold_dec;
      if (hold_dec == '0) begin
        event_closed_nxt = 1'b1;
        press_count_nxt  = '0;
      end
    end
  end

  always_comb begin
    res.clicked      = !event_closed_nxt && !key_down_nxt && in_window(press_count_nxt, cfg);
    res.long_pressed = !event_closed_nxt && above_long(press_count_nxt, cfg);
    res.busy_res     = !event_closed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_down_r     <= 1'b0;
      press_count_r  <= '0;
      half_tick_r    <= 1'b0;
      event_closed_r <= 1'b1;
      hold_cnt_r     <= '0;
    end else if (item_fire) begin
      key_down_r     <= key_down_nxt;
      press_count_r  <= press_count_nxt;
      half_tick_r    <= half_tick_nxt;
      event_closed_r <= event_closed_nxt;
      hold_cnt_r     <= hold_cnt_nxt;
    end
  end

endmodule

@@ design/button_click_long_press_detector_top.sv @@
// Top level of the button click / long-press detector: register file,
// event core and a two-entry result queue. Depends on bclp_pkg and bclp_core.
//
// One item (tick or consume request) is taken every clock cycle unless the
// input stalls. Its result is written into a two-entry queue at the edge of
// the transfer and shows on the out_ ports once earlier results are taken.
// The input stalls only when both queue entries hold results that have not
// been taken. The event state is updated from the accepted item, the
// current state and the four threshold registers, which are written over the
// APB-style port at byte addresses 0, 4, 8 and 12 (low eight bits used).
module button_click_long_press_detector_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic                           in_key_pressed,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_clicked,
  output logic                           out_long_pressed,
  output logic                           out_busy_res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bclp_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  bclp_pkg::cfg_t    cfg_r;
  bclp_pkg::reg_idx_t reg_idx;
  bclp_pkg::res_t    res;
  bclp_pkg::res_t    queue_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r, count_nxt;
  logic              in_fire, out_fire, cfg_write;
  logic [bclp_pkg::CfgWidth-1:0] rd_val;

  assign pready    = 1'b1;
  assign reg_idx   = bclp_pkg::reg_idx_t'(paddr[bclp_pkg::AddrWidth-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.click_min        <= bclp_pkg::ClickMinRst;
      cfg_r.click_max        <= bclp_pkg::ClickMaxRst;
      cfg_r.long_threshold   <= bclp_pkg::LongThreshRst;
      cfg_r.click_hold_ticks <= bclp_pkg::HoldTicksRst;
    end else if (cfg_write) begin
      unique case (reg_idx)
        bclp_pkg::REG_CLICK_MIN:   cfg_r.click_min        <= pwdata[bclp_pkg::CfgWidth-1:0];
        bclp_pkg::REG_CLICK_MAX:   cfg_r.click_max        <= pwdata[bclp_pkg::CfgWidth-1:0];
        bclp_pkg::REG_LONG_THRESH: cfg_r.long_threshold   <= pwdata[bclp_pkg::CfgWidth-1:0];
        bclp_pkg::REG_HOLD_TICKS:  cfg_r.click_hold_ticks <= pwdata[bclp_pkg::CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bclp_pkg::REG_CLICK_MIN:   rd_val = cfg_r.click_min;
      bclp_pkg::REG_CLICK_MAX:   rd_val = cfg_r.click_max;
      bclp_pkg::REG_LONG_THRESH: rd_val = cfg_r.long_threshold;
      bclp_pkg::REG_HOLD_TICKS:  rd_val = cfg_r.click_hold_ticks;
      default:                   rd_val = '0;
    endcase
  end
  assign prdata = 32'(rd_val);

  assign in_stall  = (count_r == 2'd2);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (count_r != 2'd0);
  assign out_fire  = out_valid && !out_stall;

  bclp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (in_fire),
    .item_op   (bclp_pkg::op_t'(in_operation)),
    .item_key  (in_key_pressed),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_comb begin
    count_nxt = count_r;
    if (in_fire && !out_fire) begin
      count_nxt = count_r + 2'd1;
    end else if (out_fire && !in_fire) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (out_fire) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      queue_r[wr_ptr_r] <= res;
    end
  end

  assign out_clicked      = queue_r[rd_ptr_r].clicked;
  assign out_long_pressed = queue_r[rd_ptr_r].long_pressed;
  assign out_busy_res     = queue_r[rd_ptr_r].busy_res;

endmodule

@@ design/bclp_checker.sv @@
// Port-level checks for the detector top level, attached with a bind.
// Depends only on the port names of button_click_long_press_detector_top.
module bclp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_clicked,
  input logic out_long_pressed,
  input logic out_busy_res
);

  // The input can only be held off while results are waiting.
  a_stall_needs_results: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty result queue");

  // A result that is not taken stays on offer.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result withdrawn while stalled");

  // A click or a long press is only reported for an open event.
  a_flags_need_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_clicked || out_long_pressed)) |-> out_busy_res)
    else $error("click or long press reported without an open event");

  // Reset empties the result queue.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind button_click_long_press_detector_top bclp_checker u_bclp_checker (.*);
